FILE: design/fjpt_pkg.sv
`default_nettype none

package fjpt_pkg;

   // Default geometry of the key and value stores.
   localparam int unsigned ENTRY_LEN_DEF = 32;
   localparam int unsigned PAIRS_DEF     = 64;

   // Width and reset value of the pair limit register.
   localparam int unsigned MAX_PAIRS_W     = 7;
   localparam logic [6:0]  MAX_PAIRS_RESET = 7'd16;

   localparam int unsigned CHAR_W = 8;

   // Bytes with a structural meaning; none of them is stored as a character, though zero is written as the terminator.
   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [1:0] {
      PH_SEEK  = 2'b01,
      PH_PARSE = 2'b10
   } phase_type;

   // Flag bits of one result beat.
   typedef struct packed {
      logic write_valid;
      logic write_to_key;
      logic message_done;
      logic parse_ok;
   } flags_type;

endpackage

`default_nettype wire

FILE: design/flat_json_pair_tokenizer.sv
// The result beat of an accepted byte is registered and is shown in the cycle after it is taken.
// Throughput: one byte per cycle unless the result side holds a stall; the whole decision for
// a byte is one combinational pass from the parser state register to the result register.
// Reset (synchronous, active high) clears the parser state and the result valid, and sets the
// pair limit to 16. The zero byte that ends a message also returns the parser to its reset state.
`default_nettype none

module flat_json_pair_tokenizer #(
   parameter int unsigned ENTRY_LEN = fjpt_pkg::ENTRY_LEN_DEF,
   parameter int unsigned PAIRS     = fjpt_pkg::PAIRS_DEF,
   parameter int unsigned POS_W     = $clog2(ENTRY_LEN),
   parameter int unsigned IDX_W     = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Byte input channel.
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_char_in,
   // Result channel.
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_write_valid,
   output logic                  rsp_write_to_key,
   output logic [IDX_W-1:0]      rsp_pair_index,
   output logic [POS_W-1:0]      rsp_char_pos,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_message_done,
   output logic                  rsp_parse_ok,
   // Pair limit register write channel.
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [6:0]       csr_max_pairs
);
   import fjpt_pkg::*;

   localparam int unsigned CNT_W = $clog2(PAIRS + 1);

   // Parser state. Each beat is decided from these registers and the incoming byte alone.
   phase_type        phase_ff, phase_in;
   logic             in_key_ff, in_key_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [CNT_W-1:0] pair_count_ff, pair_count_in;
   logic [6:0]       max_pairs_ff;

   // Result register. Its valid bit is control state; the payload carries no reset.
   logic             rsp_valid_ff;
   flags_type        flags_ff, flags_in;
   logic [IDX_W-1:0] pair_index_ff, pair_index_in;
   logic [POS_W-1:0] char_pos_ff, char_pos_in;
   logic [7:0]       char_out_ff, char_out_in;

   logic req_accept;

   // The result register takes a new beat whenever it is empty or is being drained in the
   // same cycle, so bytes flow at full rate unless the result side holds a stall.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Always accepted; the user must make writes only while idle; the block does no check.
   assign csr_ready = 1'b1;

   fjpt_step #(
      .ENTRY_LEN (ENTRY_LEN),
      .PAIRS     (PAIRS),
      .POS_W     (POS_W),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_step (
      .char_in         (req_char_in),
      .max_pairs       (max_pairs_ff),
      .phase           (phase_ff),
      .in_key          (in_key_ff),
      .position        (position_ff),
      .pair_count      (pair_count_ff),
      .phase_nxt       (phase_in),
      .in_key_nxt      (in_key_in),
      .position_nxt    (position_in),
      .pair_count_nxt  (pair_count_in),
      .flags           (flags_in),
      .pair_index      (pair_index_in),
      .char_pos        (char_pos_in),
      .char_out        (char_out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SEEK;
         in_key_ff      <= 1'b1;
         position_ff    <= '0;
         pair_count_ff  <= '0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         in_key_ff      <= in_key_in;
         position_ff    <= position_in;
         pair_count_ff  <= pair_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff <= MAX_PAIRS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_pairs_ff <= csr_max_pairs;
      end
   end

   // The valid bit is set by an accepted byte and cleared once its beat has been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         flags_ff      <= flags_in;
         pair_index_ff <= pair_index_in;
         char_pos_ff   <= char_pos_in;
         char_out_ff   <= char_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_valid  = flags_ff.write_valid;
   assign rsp_write_to_key = flags_ff.write_to_key;
   assign rsp_pair_index   = pair_index_ff;
   assign rsp_char_pos     = char_pos_ff;
   assign rsp_char_out     = char_out_ff;
   assign rsp_message_done = flags_ff.message_done;
   assign rsp_parse_ok     = flags_ff.parse_ok;

   // Every accepted byte leaves a result beat waiting in the next cycle.
   a_accept_gives_beat : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result beat");

   // The ending zero byte returns the parser to its idle state.
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_char_in == CH_END)) |=>
         (phase_ff == PH_SEEK) && (pair_count_ff == '0) && (position_ff == '0) &&
         in_key_ff)
      else $error("parser state not cleared after end of message");

   // parse_ok only ever accompanies the end-of-message beat.
   a_ok_with_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && flags_ff.parse_ok) |-> flags_ff.message_done)
      else $error("parse_ok set on a beat that does not end the message");

   // A character beat always lands below the last position of an entry.
   a_char_in_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && flags_ff.write_valid && (char_out_ff != CH_END)) |->
         (char_pos_ff < POS_W'(ENTRY_LEN - 1)))
      else $error("character written at the terminator-only position");

   // The completed pair count never runs past the store depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= CNT_W'(PAIRS))
      else $error("pair count beyond store depth");

endmodule

`default_nettype wire

FILE: design/fjpt_step.sv
`default_nettype none

module fjpt_step #(
   parameter int unsigned ENTRY_LEN = fjpt_pkg::ENTRY_LEN_DEF,
   parameter int unsigned PAIRS     = fjpt_pkg::PAIRS_DEF,
   parameter int unsigned POS_W     = $clog2(ENTRY_LEN),
   parameter int unsigned IDX_W     = (PAIRS > 1) ? $clog2(PAIRS) : 1,
   parameter int unsigned CNT_W     = $clog2(PAIRS + 1)
) (
   input  wire logic [7:0]             char_in,
   input  wire logic [6:0]             max_pairs,
   input  wire fjpt_pkg::phase_type    phase,
   input  wire logic                   in_key,
   input  wire logic [POS_W-1:0]       position,
   input  wire logic [CNT_W-1:0]       pair_count,
   output fjpt_pkg::phase_type         phase_nxt,
   output logic                        in_key_nxt,
   output logic [POS_W-1:0]            position_nxt,
   output logic [CNT_W-1:0]            pair_count_nxt,
   output fjpt_pkg::flags_type         flags,
   output logic [IDX_W-1:0]            pair_index,
   output logic [POS_W-1:0]            char_pos,
   output logic [7:0]                  char_out
);
   import fjpt_pkg::*;

   localparam int unsigned CMP_W = (CNT_W > MAX_PAIRS_W) ? CNT_W : MAX_PAIRS_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(ENTRY_LEN - 1);

   logic [CMP_W-1:0] limit;
   logic [CMP_W-1:0] count_ext;
   logic             room;
   logic             ignored;

   // A register value above the store depth is clipped to the depth.
   always_comb begin
      if (CMP_W'(max_pairs) > CMP_W'(PAIRS)) begin
         limit = CMP_W'(PAIRS);
      end else begin
         limit = CMP_W'(max_pairs);
      end
   end

   assign count_ext = CMP_W'(pair_count);
   assign room      = count_ext < limit;
   assign ignored   = (char_in == CH_QUOTE)  || (char_in == CH_LBRACE) ||
                      (char_in == CH_RBRACE) || (char_in == CH_LBRACK) ||
                      (char_in == CH_RBRACK);

   always_comb begin
      phase_nxt       = phase;
      in_key_nxt      = in_key;
      position_nxt    = position;
      pair_count_nxt  = pair_count;
      flags           = '0;
      pair_index      = '0;
      char_pos        = '0;
      char_out        = '0;

      if (char_in == CH_END) begin
         if (phase == PH_PARSE) begin
            if (room) begin
               flags.write_valid = 1'b1;
               pair_index        = pair_count[IDX_W-1:0];
               char_pos          = position;
            end
            flags.parse_ok = 1'b1;
         end
         flags.message_done = 1'b1;
         phase_nxt          = PH_SEEK;
         in_key_nxt         = 1'b1;
         position_nxt       = '0;
         pair_count_nxt     = '0;
      end else if (phase != PH_PARSE) begin
         if (char_in == CH_QUOTE) begin
            phase_nxt = PH_PARSE;
         end
      end else if (room) begin
         if (char_in == CH_COLON) begin
            flags.write_valid  = 1'b1;
            flags.write_to_key = 1'b1;
            pair_index         = pair_count[IDX_W-1:0];
            char_pos           = position;
            position_nxt       = '0;
            in_key_nxt         = 1'b0;
         end else if (char_in == CH_COMMA) begin
            flags.write_valid = 1'b1;
            pair_index        = pair_count[IDX_W-1:0];
            char_pos          = position;
            position_nxt      = '0;
            pair_count_nxt    = pair_count + CNT_W'(1);
            in_key_nxt        = 1'b1;
         end else if (!ignored && (position < POS_LAST)) begin
            flags.write_valid  = 1'b1;
            flags.write_to_key = in_key;
            pair_index         = pair_count[IDX_W-1:0];
            char_pos           = position;
            char_out           = char_in;
            position_nxt       = position + POS_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/tb_flat_json_pair_tokenizer.sv
`default_nettype none

module tb_flat_json_pair_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import fjpt_pkg::*;

   // First position at which characters are dropped; only a terminator may
   // land here, and nothing goes beyond it.
   localparam int unsigned LAST_POS = ENTRY_LEN_DEF - 1;

   // The slowest correct run covers about 1200 bytes, each waiting out sender gaps and
   // receiver stalls, plus one long receiver hold-off. The limit is set well clear of that.
   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int ITEMS_PER_PHASE  = 200;
   localparam int RANDOM_PHASES    = 6;
   localparam int MISMATCH_REPORTS = 10;

   // One result beat, one member per result port.
   typedef struct packed {
      logic       write_valid;
      logic       write_to_key;
      logic [5:0] pair_index;
      logic [4:0] char_pos;
      logic [7:0] char_out;
      logic       message_done;
      logic       parse_ok;
   } tok_result_type;

   // One row of the directed table. Where typed is set, res holds the result
   // written out by hand; otherwise the tokenizer model supplies it.
   typedef struct packed {
      logic [7:0]     ch;
      logic           typed;
      tok_result_type res;
   } plan_row_type;

   // Clock and reset. Reset is high from time zero and is released once.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Every input of the block starts at a known value.
   logic       req_valid     = 1'b0;
   logic [7:0] req_char_in   = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       csr_valid     = 1'b0;
   logic [6:0] csr_max_pairs = 7'd0;

   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_write_valid;
   logic       rsp_write_to_key;
   logic [5:0] rsp_pair_index;
   logic [4:0] rsp_char_pos;
   logic [7:0] rsp_char_out;
   logic       rsp_message_done;
   logic       rsp_parse_ok;
   logic       csr_ready;

   flat_json_pair_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_to_key (rsp_write_to_key),
      .rsp_pair_index   (rsp_pair_index),
      .rsp_char_pos     (rsp_char_pos),
      .rsp_char_out     (rsp_char_out),
      .rsp_message_done (rsp_message_done),
      .rsp_parse_ok     (rsp_parse_ok),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_pairs    (csr_max_pairs)
   );

   // Hand-written expectation that travels with the byte on the input channel.
   // It is driven alongside req_char_in, so it is stable while that beat stalls.
   logic           drv_typed     = 1'b0;
   tok_result_type drv_typed_res = '0;

   // Idling rates in percent for each side, changed only between phases.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Long receiver hold-off, requested by the stimulus and timed by its own process.
   event start_hold_off;
   logic receiver_hold = 1'b0;

   int cycle_count    = 0;
   int mismatch_count = 0;

   tok_result_type expected_writes [$];
   plan_row_type   directed_plan [$];
   logic [7:0]     message_bytes [$];

   // ---------------------------------------------------------------------------
   // Tokenizer model: its own copy of the parser state and of the pair limit.
   // ---------------------------------------------------------------------------
   phase_type  parse_phase;
   logic       in_key;
   logic [4:0] position;
   logic [6:0] pairs_done;
   logic [6:0] pair_limit_reg;

   task clear_parser();
      parse_phase = PH_SEEK;
      in_key      = 1'b1;
      position    = '0;
      pairs_done  = '0;
   endtask

   // A store write at the current pair.
   function automatic tok_result_type store_write(input logic to_key, input logic [4:0] pos,
                                                  input logic [7:0] ch);
      tok_result_type r;
      r              = '0;
      r.write_valid  = 1'b1;
      r.write_to_key = to_key;
      r.pair_index   = pairs_done[5:0];
      r.char_pos     = pos;
      r.char_out     = ch;
      return r;
   endfunction

   task predict_byte(input logic [7:0] c, output tok_result_type r);
      logic [6:0] eff_limit;
      logic       room;
      // Limits above the store depth behave as the full depth; zero allows nothing.
      eff_limit = (pair_limit_reg > 7'(PAIRS_DEF)) ? 7'(PAIRS_DEF) : pair_limit_reg;
      room      = pairs_done < eff_limit;
      r         = '0;
      if (c == CH_END) begin
         // The ending byte closes the current value, if there is still room,
         // and always returns the parser to its starting state.
         if (parse_phase == PH_PARSE) begin
            if (room)
               r = store_write(1'b0, position, 8'h00);
            r.parse_ok = 1'b1;
         end
         r.message_done = 1'b1;
         clear_parser();
      end else if (parse_phase == PH_SEEK) begin
         if (c == CH_QUOTE)
            parse_phase = PH_PARSE;
      end else if (room) begin
         case (c)
            CH_COLON: begin
               // Ends the key, even when a value is already being read.
               r           = store_write(1'b1, position, 8'h00);
               position    = '0;
               in_key      = 1'b0;
            end
            CH_COMMA: begin
               r           = store_write(1'b0, position, 8'h00);
               position    = '0;
               pairs_done  = pairs_done + 7'd1;
               in_key      = 1'b1;
            end
            CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK: ;
            default: begin
               // Characters past the last storable position are dropped.
               if (position < LAST_POS) begin
                  r        = store_write(in_key, position, c);
                  position = position + 5'd1;
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, where the values seen are
   // those from before the edge, so the order of processes does not matter.
   // Result beats are checked before the new expectation is queued.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      tok_result_type got;
      tok_result_type want;
      tok_result_type predicted;
      logic           differs;
      if (reset) begin
         clear_parser();
         pair_limit_reg = MAX_PAIRS_RESET;
      end else begin
         if (csr_valid && csr_ready)
            pair_limit_reg = csr_max_pairs;

         if (rsp_valid && !rsp_stall) begin
            got.write_valid  = rsp_write_valid;
            got.write_to_key = rsp_write_to_key;
            got.pair_index   = rsp_pair_index;
            got.char_pos     = rsp_char_pos;
            got.char_out     = rsp_char_out;
            got.message_done = rsp_message_done;
            got.parse_ok     = rsp_parse_ok;
            if (expected_writes.size() == 0) begin
               if (mismatch_count < MISMATCH_REPORTS)
                  $display("cycle %0d: result beat with nothing expected: wv=%0d key=%0d",
                           cycle_count, got.write_valid, got.write_to_key);
               mismatch_count = mismatch_count + 1;
            end else begin
               want    = expected_writes.pop_front();
               differs = (got.write_valid  !== want.write_valid)  ||
                         (got.write_to_key !== want.write_to_key) ||
                         (got.pair_index   !== want.pair_index)   ||
                         (got.char_pos     !== want.char_pos)     ||
                         (got.char_out     !== want.char_out)     ||
                         (got.message_done !== want.message_done) ||
                         (got.parse_ok     !== want.parse_ok);
               if (differs) begin
                  if (mismatch_count < MISMATCH_REPORTS) begin
                     $display("cycle %0d exp: wv=%0d key=%0d idx=%0d pos=%0d ch=%02h done=%0d ok=%0d",
                              cycle_count, want.write_valid, want.write_to_key,
                              want.pair_index, want.char_pos, want.char_out,
                              want.message_done, want.parse_ok);
                     $display("cycle %0d act: wv=%0d key=%0d idx=%0d pos=%0d ch=%02h done=%0d ok=%0d",
                              cycle_count, got.write_valid, got.write_to_key,
                              got.pair_index, got.char_pos, got.char_out,
                              got.message_done, got.parse_ok);
                  end
                  mismatch_count = mismatch_count + 1;
               end
            end
         end

         if (req_valid && !req_stall) begin
            // The model always runs so that its state follows the block, even
            // when the row brings its own expectation.
            predict_byte(req_char_in, predicted);
            expected_writes.push_back(drv_typed ? drv_typed_res : predicted);
         end
      end
   end

   // The receiver stalls at random, and throughout any hold-off.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= receiver_hold || ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // The hold-off keeps the result channel stalled while the sender keeps offering bytes,
   // so that the block fills up.
   initial begin : hold_off
      forever begin
         @(start_hold_off);
         receiver_hold <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         receiver_hold <= 1'b0;
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------
   function automatic tok_result_type result_of(input logic wv, input logic tk,
                                                input logic [5:0] idx, input logic [4:0] pos,
                                                input logic [7:0] ch, input logic done,
                                                input logic ok);
      tok_result_type r;
      r.write_valid  = wv;
      r.write_to_key = tk;
      r.pair_index   = idx;
      r.char_pos     = pos;
      r.char_out     = ch;
      r.message_done = done;
      r.parse_ok     = ok;
      return r;
   endfunction

   function automatic plan_row_type plan_row(input logic [7:0] ch, input logic typed,
                                             input tok_result_type res);
      plan_row_type p;
      p.ch    = ch;
      p.typed = typed;
      p.res   = res;
      return p;
   endfunction

   // Offers one byte and returns at the edge at which it is taken. Each call
   // makes exactly one assignment to req_valid per time step.
   task offer_byte(input logic [7:0] ch, input logic typed, input tok_result_type res);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_in   <= ch;
      drv_typed     <= typed;
      drv_typed_res <= res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The sender stops until every expected result beat has arrived.
   task wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   // Written only while the block is idle, once every expected result beat has arrived.
   task write_max_pairs(input logic [6:0] value);
      wait_until_drained();
      repeat (2) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_max_pairs <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_idling(input int mode);
      case (mode)
         0: begin
            sender_idle_pct    = 21;
            receiver_stall_pct = 62;
         end
         1: begin
            sender_idle_pct    = 62;
            receiver_stall_pct = 21;
         end
         default: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   // Mostly letters and digits, sometimes any non-zero byte, so that every bit
   // of the byte is exercised.
   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 4) == 0)
         return 8'($urandom_range(1, 255));
      else if ($urandom_range(0, 1) == 1)
         return 8'($urandom_range(8'h61, 8'h7A));
      else
         return 8'($urandom_range(8'h30, 8'h39));
   endfunction

   // A byte that carries no meaning before the opening quote.
   function automatic logic [7:0] skip_byte();
      logic [7:0] b;
      b = text_byte();
      return (b == CH_QUOTE) ? 8'h20 : b;
   endfunction

   function automatic logic [7:0] structural_byte();
      case ($urandom_range(0, 6))
         0:       return CH_QUOTE;
         1:       return CH_COMMA;
         2:       return CH_COLON;
         3:       return CH_LBRACE;
         4:       return CH_RBRACE;
         5:       return CH_LBRACK;
         default: return CH_RBRACK;
      endcase
   endfunction

   // Entries are mostly short; now and then one runs past the end of its slot.
   function automatic int entry_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
   endfunction

   task push_entry();
      int n;
      n = entry_length();
      repeat (n) message_bytes.push_back(text_byte());
   endtask

   // Builds one message into message_bytes. Most messages are well formed with
   // random content; the rest are broken sequences or have no quote at all.
   task build_message();
      int kind;
      int npairs;
      int n;
      message_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n) message_bytes.push_back(skip_byte());
         message_bytes.push_back(CH_LBRACE);
         npairs = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
         for (int p = 0; p < npairs; p++) begin
            message_bytes.push_back(CH_QUOTE);
            push_entry();
            message_bytes.push_back(CH_QUOTE);
            message_bytes.push_back(CH_COLON);
            message_bytes.push_back(CH_QUOTE);
            push_entry();
            message_bytes.push_back(CH_QUOTE);
            if (p != npairs - 1)
               message_bytes.push_back(CH_COMMA);
         end
         message_bytes.push_back(CH_RBRACE);
      end else if (kind < 95) begin
         n = $urandom_range(1, 20);
         repeat (n)
            message_bytes.push_back(($urandom_range(0, 1) == 1) ? structural_byte() : text_byte());
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) message_bytes.push_back(skip_byte());
      end
      message_bytes.push_back(CH_END);
   endtask

   function automatic logic [6:0] phase_limit(input int ph);
      case (ph)
         0:       return 7'd1;
         1:       return 7'd64;
         2:       return 7'd0;
         3:       return 7'd127;
         4:       return 7'd65;
         default: return 7'($urandom_range(2, 63));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int sent_in_phase;
      int msg_in_phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, run with the pair limit at its reset value of 16. The
      // first rows after reset and the extremes are written out by hand.
      directed_plan.push_back(plan_row(CH_END, 1'b1, result_of(0, 0, 0, 0, 8'h00, 1, 0)));
      directed_plan.push_back(plan_row(8'h78,  1'b1, result_of(0, 0, 0, 0, 8'h00, 0, 0)));
      directed_plan.push_back(plan_row(CH_QUOTE, 1'b1, result_of(0, 0, 0, 0, 8'h00, 0, 0)));
      directed_plan.push_back(plan_row(8'hFF,  1'b1, result_of(1, 1, 0, 0, 8'hFF, 0, 0)));
      directed_plan.push_back(plan_row(8'h01,     1'b0, '0));
      directed_plan.push_back(plan_row(CH_LBRACE, 1'b0, '0));
      directed_plan.push_back(plan_row(CH_LBRACK, 1'b0, '0));
      directed_plan.push_back(plan_row(CH_RBRACK, 1'b0, '0));
      directed_plan.push_back(plan_row(CH_RBRACE, 1'b0, '0));
      directed_plan.push_back(plan_row(CH_QUOTE,  1'b0, '0));
      directed_plan.push_back(plan_row(CH_COLON,  1'b0, '0));
      directed_plan.push_back(plan_row(8'h80,     1'b0, '0));
      // A colon inside a value still closes the key at the current position.
      directed_plan.push_back(plan_row(CH_COLON,  1'b0, '0));
      directed_plan.push_back(plan_row(8'h37,     1'b0, '0));
      directed_plan.push_back(plan_row(CH_COMMA,  1'b0, '0));
      directed_plan.push_back(plan_row(8'h6B,     1'b0, '0));
      directed_plan.push_back(plan_row(CH_COMMA,  1'b0, '0));
      // The ending byte closes the value of the third pair at position zero.
      directed_plan.push_back(plan_row(CH_END, 1'b1, result_of(1, 0, 2, 0, 8'h00, 1, 1)));
      // Parser is back in its starting state, so this one finds no quote.
      directed_plan.push_back(plan_row(CH_END, 1'b1, result_of(0, 0, 0, 0, 8'h00, 1, 0)));
      directed_plan.push_back(plan_row(CH_QUOTE, 1'b0, '0));
      directed_plan.push_back(plan_row(8'h7F,    1'b0, '0));
      directed_plan.push_back(plan_row(CH_END,   1'b0, '0));

      set_idling(0);
      foreach (directed_plan[i])
         offer_byte(directed_plan[i].ch, directed_plan[i].typed, directed_plan[i].res);
      wait_until_drained();

      // Random phases: two for each idling pattern, each with its own pair limit,
      // zero, one, the store depth and values beyond it among them.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_idling(ph / 2);
         write_max_pairs(phase_limit(ph));
         if (ph == 0)
            -> start_hold_off;
         sent_in_phase = 0;
         msg_in_phase  = 0;
         while (sent_in_phase < ITEMS_PER_PHASE) begin
            build_message();
            foreach (message_bytes[i])
               offer_byte(message_bytes[i], 1'b0, '0);
            sent_in_phase = sent_in_phase + message_bytes.size();
            msg_in_phase  = msg_in_phase + 1;
            // Now and then the sender waits for the block to empty completely.
            if (msg_in_phase == 2 || $urandom_range(0, 7) == 0)
               wait_until_drained();
         end
      end

      // Wind-down: wait for the last result beat, then wait on in case anything unexpected
      // is still on its way.
      wait_until_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && expected_writes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
design/fjpt_pkg.sv
design/fjpt_step.sv
design/flat_json_pair_tokenizer.sv
sim/tb_flat_json_pair_tokenizer.sv
